// ===== src/slsa_pkg.sv =====
package slsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 80;
    localparam int LW         = 7;                    // slot / link field width
    localparam int CW         = LW + 1;               // compare width, holds SLOT_COUNT
    localparam int AW         = $clog2(SLOT_COUNT);   // table address width
    localparam int SW         = $clog2(SLOT_COUNT);   // walk step counter width

    localparam logic [CW-1:0] SLOT_CW   = CW'(SLOT_COUNT);
    localparam logic [LW-1:0] COUNT_MAX = {LW{1'b1}};

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [LW-1:0] t_link;

endpackage

// ===== src/sprite_link_slot_allocator.sv =====
// An allocate on an empty list writes slot 0, then queues its result. Else the chain is
// walked one read per cycle, then a splice (two write-backs) or an unlink (one read, one
// write-back) precedes the result state; a full list or a miss goes straight to it.
// Throughput: one request at a time; the next request is taken the cycle after the result
// is queued. Reset (synchronous, active low) clears the controller, the live count and the
// per-slot valid bits, so the link table reads as zero right away with no clearing pass.
module sprite_link_slot_allocator
    import slsa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_req_type,
    input  logic [LW-1:0] i_free_slot,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [LW-1:0] o_slot,
    output logic [1:0]    o_status,
    output logic [LW-1:0] o_live_count
);

    // Controller state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ2 = 3'd2;
    localparam logic [2:0] S_WB1   = 3'd3;
    localparam logic [2:0] S_WB2   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic          r_req, n_req;
    t_link         r_target, n_target;
    t_link         r_cur, n_cur;
    logic [SW-1:0] r_steps, n_steps;
    t_link         r_pick, n_pick;
    t_link         r_wa, n_wa;
    logic          r_wa_ok, n_wa_ok;
    t_link         r_wd, n_wd;
    logic          r_two, n_two;
    logic          r_inc, n_inc;
    logic          r_dec, n_dec;
    t_link         r_res_slot, n_res_slot;
    logic [1:0]    r_res_status, n_res_status;
    t_link         r_live, n_live;

    logic          r_out_valid;
    t_link         r_out_slot;
    logic [1:0]    r_out_status;
    t_link         r_out_live;

    // Link table with per-slot valid bits
    t_link                 mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    t_link                 r_rd_data;
    logic                  r_rd_vld;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_link         wr_data;
    logic          wr_en;

    t_link         link;
    logic [CW-1:0] cur_inc;
    logic          last_step;
    logic          accept;
    logic          out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Link read back, out-of-range and never-written entries read as zero
    always_comb begin
        link = '0;
        if (r_rd_vld && ({1'b0, r_rd_data} < SLOT_CW)) begin
            link = r_rd_data;
        end
    end

    assign cur_inc   = {1'b0, r_cur} + CW'(1);
    assign last_step = (r_steps == SW'(SLOT_COUNT - 1));

    // Table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wa[AW-1:0];
        wr_data = r_wd;
        if (r_state == S_WB1) begin
            wr_en = r_wa_ok;
        end else if (r_state == S_WB2) begin
            wr_en   = 1'b1;
            wr_addr = r_cur[AW-1:0];
            wr_data = r_pick;
        end
    end

    // Controller
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_target     = r_target;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_pick       = r_pick;
        n_wa         = r_wa;
        n_wa_ok      = r_wa_ok;
        n_wd         = r_wd;
        n_two        = r_two;
        n_inc        = r_inc;
        n_dec        = r_dec;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_live       = r_live;
        rd_addr      = '0;

        case (r_state)
            S_IDLE: begin
                // read of slot 0 goes out with the accept
                if (accept) begin
                    n_req        = i_req_type;
                    n_target     = i_free_slot;
                    n_cur        = '0;
                    n_steps      = '0;
                    n_inc        = 1'b0;
                    n_dec        = 1'b0;
                    n_two        = 1'b0;
                    n_res_slot   = '0;
                    n_res_status = ST_OK;
                    if (i_req_type == REQ_ALLOC && r_live == '0) begin
                        // empty list: slot 0 becomes the sole entry
                        n_wa    = '0;
                        n_wa_ok = 1'b1;
                        n_wd    = '0;
                        n_inc   = 1'b1;
                        n_state = S_WB1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end

            S_CHECK: begin
                if (r_req == REQ_ALLOC) begin
                    if (link == '0 || cur_inc != {1'b0, link}) begin
                        if (link == '0 && ({1'b0, r_cur} >= SLOT_CW - CW'(1))) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            // gap after cur: splice cur+1 in
                            n_pick     = cur_inc[LW-1:0];
                            n_wa       = cur_inc[LW-1:0];
                            n_wa_ok    = cur_inc < SLOT_CW;
                            n_wd       = link;
                            n_two      = 1'b1;
                            n_inc      = 1'b1;
                            n_res_slot = cur_inc[LW-1:0];
                            n_state    = S_WB1;
                        end
                    end else if (last_step) begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_cur   = link;
                        n_steps = r_steps + SW'(1);
                        rd_addr = link[AW-1:0];
                    end
                end else begin
                    if (link == '0) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else if (link == r_target) begin
                        // fetch the victim's link; cur stays as predecessor
                        rd_addr = link[AW-1:0];
                        n_state = S_READ2;
                    end else if (last_step) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else begin
                        n_cur   = link;
                        n_steps = r_steps + SW'(1);
                        rd_addr = link[AW-1:0];
                    end
                end
            end

            S_READ2: begin
                // unlink: predecessor takes the victim's successor
                n_wa       = r_cur;
                n_wa_ok    = 1'b1;
                n_wd       = link;
                n_dec      = 1'b1;
                n_res_slot = r_target;
                n_state    = S_WB1;
            end

            S_WB1: begin
                n_state = r_two ? S_WB2 : S_DONE;
            end

            S_WB2: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                // wait for room in the output register
                if (out_free) begin
                    if (r_inc && r_live != COUNT_MAX) begin
                        n_live = r_live + LW'(1);
                    end else if (r_dec && r_live != '0) begin
                        n_live = r_live - LW'(1);
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_target     <= n_target;
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_pick       <= n_pick;
        r_wa         <= n_wa;
        r_wa_ok      <= n_wa_ok;
        r_wd         <= n_wd;
        r_two        <= n_two;
        r_inc        <= n_inc;
        r_dec        <= n_dec;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && out_free) begin
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
            r_out_live   <= n_live;
        end
    end

    // Link table memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_out_slot;
    assign o_status     = r_out_status;
    assign o_live_count = r_out_live;

    // A failed request always reports slot zero
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_slot == '0))
        else $error("failed request reports a nonzero slot");

    // Live count never exceeds the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_live} <= SLOT_CW))
        else $error("live count above table size");

    // An accepted request occupies the controller on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("controller idle right after accept");

    // Table writes happen only in write-back states
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_WB1 || r_state == S_WB2))
        else $error("table write outside write-back");

    // Live count moves only when a result is queued
    a_live_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live != $past(r_live)) |-> ($past(r_state) == S_DONE))
        else $error("live count changed outside result cycle");

endmodule

// ===== tb/slot_chain_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the link chain and checks every result.
module slot_chain_checker
    import slsa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  logic          i_req_type,
    input  logic [LW-1:0] i_free_slot,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  logic [LW-1:0] i_slot,
    input  logic [1:0]    i_status,
    input  logic [LW-1:0] i_live_count,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_full_hits
);

    typedef struct packed {
        t_link      slot;
        logic [1:0] status;
        t_link      count;
    } t_grant;

    t_link  chain_link [SLOT_COUNT];
    t_link  live_total;
    t_grant awaited_grants [$];
    int     fail_cnt = 0;
    int     full_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = awaited_grants.size();
    assign o_full_hits  = full_cnt;

    // Link read; anything out of range ends the walk like a zero link
    function automatic int follow(input int idx);
        if (idx >= SLOT_COUNT) return 0;
        if (int'(chain_link[idx]) >= SLOT_COUNT) return 0;
        return int'(chain_link[idx]);
    endfunction

    // Apply one request to the chain copy and return the grant it produces
    function automatic t_grant serve_request(input logic req, input t_link target);
        t_grant g;
        int     cur;
        int     nxt;
        int     pick;
        int     prev;
        int     idx;
        int     steps;
        bit     got;
        g.slot   = '0;
        g.status = ST_OK;
        g.count  = '0;
        cur  = 0;
        nxt  = 0;
        pick = 0;
        got  = 1'b0;
        if (req == REQ_ALLOC) begin
            if (live_total == '0) begin
                // empty list always takes slot 0
                live_total    = t_link'(1);
                chain_link[0] = '0;
            end else begin
                // first hole right after a live slot
                for (steps = 0; steps < SLOT_COUNT; steps++) begin
                    nxt = follow(cur);
                    if (nxt == 0) begin
                        if (cur < SLOT_COUNT - 1) begin
                            pick = cur + 1;
                            got  = 1'b1;
                        end
                        break;
                    end
                    if (cur + 1 != nxt) begin
                        pick = cur + 1;
                        got  = 1'b1;
                        break;
                    end
                    cur = nxt;
                end
                if (got) begin
                    chain_link[pick] = t_link'(nxt);
                    chain_link[cur]  = t_link'(pick);
                    if (live_total != COUNT_MAX) live_total = live_total + t_link'(1);
                    g.slot = t_link'(pick);
                end else begin
                    g.status = ST_FULL;
                end
            end
        end else begin
            // unlink target; slot 0 is never a match
            g.status = ST_NOT_FOUND;
            idx = 0;
            for (steps = 0; steps < SLOT_COUNT; steps++) begin
                prev = idx;
                idx  = follow(idx);
                if (idx == 0) break;
                if (idx == int'(target)) begin
                    chain_link[prev] = t_link'(follow(idx));
                    if (live_total != '0) live_total = live_total - t_link'(1);
                    g.slot   = target;
                    g.status = ST_OK;
                    break;
                end
            end
        end
        g.count = live_total;
        return g;
    endfunction

    task automatic note_failure(input string what, input t_grant want, input t_grant got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display({"%0t %s: expected slot %0d status %0d count %0d,",
                      " got slot %0d status %0d count %0d"},
                     $realtime, what, want.slot, want.status, want.count,
                     got.slot, got.status, got.count);
    endtask

    // Sample both handshakes at the edge; results before requests
    always @(posedge i_clk) begin : watch
        t_grant want;
        t_grant seen;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) chain_link[k] = '0;
            live_total = '0;
            awaited_grants.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen.slot   = i_slot;
                seen.status = i_status;
                seen.count  = i_live_count;
                if (awaited_grants.size() == 0) begin
                    want = '0;
                    note_failure("result with no request outstanding", want, seen);
                end else begin
                    want = awaited_grants.pop_front();
                    if (want.status == ST_FULL) full_cnt++;
                    if (seen.slot !== want.slot || seen.status !== want.status ||
                        seen.count !== want.count)
                        note_failure("result mismatch", want, seen);
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_grants.push_back(serve_request(i_req_type, i_free_slot));
        end
    end

endmodule

// ===== tb/sprite_link_slot_allocator_test.sv =====
`timescale 1ns / 100ps

module sprite_link_slot_allocator_test;
    import slsa_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic          req_type;
    logic [LW-1:0] free_slot;
    logic          out_valid;
    logic          out_stall;
    logic [LW-1:0] slot;
    logic [1:0]    status;
    logic [LW-1:0] live_count;

    int fail_count;
    int pending;
    int full_hits;
    int sent_alloc = 0;
    int sent_free  = 0;
    int calm_left  = 0;

    sprite_link_slot_allocator u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_free_slot  (free_slot),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_slot       (slot),
        .o_status     (status),
        .o_live_count (live_count)
    );

    slot_chain_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_free_slot  (free_slot),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_slot       (slot),
        .i_status     (status),
        .i_live_count (live_count),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_full_hits  (full_hits)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_req(input logic req, input t_link target);
        int gap;
        if (calm_left > 0) begin
            gap = 0;
            calm_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        free_slot <= target;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (req == REQ_ALLOC) sent_alloc++;
        else sent_free++;
    endtask

    task automatic alloc_req();
        send_req(REQ_ALLOC, t_link'($urandom_range(0, 127)));
    endtask

    // Hold off until every outstanding request has answered
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver back-pressure: calm stretches, short and occasional long stalls
    initial begin
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 400)) @(posedge clk);
            end
            begin : stall_burst
                int hold;
                hold = pick_gap();
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Stimulus
    initial begin
        int   kind;
        int   len;
        logic req;
        in_valid  <= 1'b0;
        req_type  <= REQ_ALLOC;
        free_slot <= '0;
        rst_n     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // free on empty list, including out-of-range slot
        send_req(REQ_FREE, t_link'(0));
        send_req(REQ_FREE, t_link'(5));
        send_req(REQ_FREE, t_link'(127));
        // allocate on empty list takes slot 0
        alloc_req();
        // slot 0 can never be freed
        send_req(REQ_FREE, t_link'(0));
        repeat (4) alloc_req();
        send_req(REQ_FREE, t_link'(2));
        send_req(REQ_FREE, t_link'(2));
        send_req(REQ_FREE, t_link'(80));
        send_req(REQ_FREE, t_link'(127));
        alloc_req();
        // tail, then the new tail
        send_req(REQ_FREE, t_link'(4));
        send_req(REQ_FREE, t_link'(3));
        alloc_req();
        alloc_req();
        send_req(REQ_FREE, t_link'(1));
        send_req(REQ_FREE, t_link'(79));
        send_req(REQ_FREE, t_link'(85));
        send_req(REQ_FREE, t_link'(42));
        drain_all();

        // fill to the top so the full list shows up, then poke at it
        repeat (82) alloc_req();
        send_req(REQ_FREE, t_link'(SLOT_COUNT - 1));
        alloc_req();
        send_req(REQ_FREE, t_link'(40));
        send_req(REQ_FREE, t_link'(1));
        alloc_req();
        alloc_req();
        alloc_req();
        drain_all();

        // random phases: filling, draining, mixed and noisy
        while (sent_alloc + sent_free < 1850) begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(20, 120);
            repeat (len) begin
                case (kind)
                    0: req = ($urandom_range(0, 9) < 9) ? REQ_ALLOC : REQ_FREE;
                    1: req = ($urandom_range(0, 9) < 8) ? REQ_FREE : REQ_ALLOC;
                    2: req = ($urandom_range(0, 1) == 0) ? REQ_ALLOC : REQ_FREE;
                    default: req = ($urandom_range(0, 9) < 7) ? REQ_FREE : REQ_ALLOC;
                endcase
                if (req == REQ_ALLOC) alloc_req();
                else if (kind == 3) send_req(REQ_FREE, t_link'($urandom_range(0, 127)));
                else send_req(REQ_FREE, t_link'($urandom_range(1, SLOT_COUNT - 1)));
            end
            if ($urandom_range(0, 5) == 0) drain_all();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d allocate and %0d free requests; the full list was reported %0d times.",
                 sent_alloc, sent_free, full_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("sprite_link_slot_allocator_test: clean");
        end else begin
            $display("sprite_link_slot_allocator_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("sprite_link_slot_allocator_test: errors");
        $finish;
    end

endmodule
